[rtl/core/pfe_pkg.sv]
`default_nettype none

package pfe_pkg;

  localparam int WORD_W = 32;
  localparam int DEFAULT_STACK_DEPTH = 128;

  // Character codes of the postfix text.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_TIMES = 8'h2A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Bit positions in the error flags.
  localparam int FLAG_UNDER = 0;
  localparam int FLAG_OVER  = 1;
  localparam int FLAG_DIVZ  = 2;
  localparam int FLAG_W     = 3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_ABOVE,
    CELL_TAKE_BELOW
  } cell_op_t;

  function automatic logic is_digit(input logic [7:0] sym);
    return (sym >= CH_ZERO) && (sym <= CH_NINE);
  endfunction

  function automatic logic is_arith_op(input logic [7:0] sym);
    return (sym == CH_PLUS) || (sym == CH_TIMES) || (sym == CH_MINUS) || (sym == CH_SLASH);
  endfunction

endpackage

`default_nettype wire

[rtl/core/pfe_cell.sv]
`default_nettype none

module pfe_cell (
  input  wire logic                        clk,
  input  wire pfe_pkg::cell_op_t           ctrl,
  input  wire logic [pfe_pkg::WORD_W-1:0]  from_above,
  input  wire logic [pfe_pkg::WORD_W-1:0]  from_below,
  output logic      [pfe_pkg::WORD_W-1:0]  value
);

  always_ff @(posedge clk) begin
    case (ctrl)
      pfe_pkg::CELL_TAKE_ABOVE: value <= from_above;
      pfe_pkg::CELL_TAKE_BELOW: value <= from_below;
      default: value <= value;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/pfe_div.sv]
`default_nettype none

module pfe_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pfe_pkg::WORD_W-1:0]  dividend,
  input  wire logic [pfe_pkg::WORD_W-1:0]  divisor,
  output logic                             done,
  output logic      [pfe_pkg::WORD_W-1:0]  quotient
);

  localparam int W = pfe_pkg::WORD_W;
  localparam int STEP_W = $clog2(W);

  logic              busy;
  logic [STEP_W-1:0] step_cnt;
  logic [W-1:0]      rem;
  logic [W-1:0]      quo;
  logic [W-1:0]      dvs;
  logic              neg;

  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic         q_bit;
  logic [W-1:0] rem_next;
  logic [W-1:0] quo_next;

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_comb begin
    rem_sh   = {rem, quo[W-1]};
    diff     = rem_sh - {1'b0, dvs};
    q_bit    = ~diff[W];
    rem_next = q_bit ? diff[W-1:0] : rem_sh[W-1:0];
    quo_next = {quo[W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= '0;
        rem      <= '0;
        quo      <= dividend[W-1] ? W'(0) - dividend : dividend;
        dvs      <= divisor[W-1] ? W'(0) - divisor : divisor;
        neg      <= dividend[W-1] ^ divisor[W-1];
      end else if (busy) begin
        rem      <= rem_next;
        quo      <= quo_next;
        step_cnt <= step_cnt + STEP_W'(1);
        if (step_cnt == STEP_W'(W - 1)) begin
          busy     <= 1'b0;
          done     <= 1'b1;
          quotient <= neg ? W'(0) - quo_next : quo_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/postfix_expression_evaluator.sv]
// A digit word is added into the accumulator in S_IDLE; an operator word is then reduced in S_OP,
// after a push in S_NUM when a number is pending; a division waits in S_DIV on the radix-2 divider
// (one bit a cycle). A tlast word ends in S_FINAL, which waits until the previous result is taken.
// Throughput: one digit per cycle; the stack cell row takes one push or one reduction a cycle.
// Reset clears the count, accumulator, flags and output valid; stack cells are not cleared.
`default_nettype none

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfe_pkg::DEFAULT_STACK_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] symbol
  input  wire logic        s_tlast,   // last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [31:0] value
  output logic      [2:0]  m_tuser    // [0] underflow, [1] overflow, [2] divide_by_zero
);

  localparam int W = pfe_pkg::WORD_W;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NUM,
    S_OP,
    S_DIV,
    S_FINAL
  } state_t;

  state_t                      state;
  logic [7:0]                  sym_r;
  logic                        last_r;
  logic [W-1:0]                acc;
  logic                        in_num;
  logic [CNT_W-1:0]            stack_count;
  logic [pfe_pkg::FLAG_W-1:0]  flags;

  logic [W-1:0]       cell_val [STACK_DEPTH];
  pfe_pkg::cell_op_t  ctrl_top;
  pfe_pkg::cell_op_t  ctrl_rest;
  logic [W-1:0]       top_in;

  logic               full;
  logic               short_stack;
  logic               out_free;
  logic               emit;
  logic [W-1:0]       r_opnd;
  logic [W-1:0]       l_opnd;
  logic [W-1:0]       alu_res;
  logic [CNT_W-1:0]   count_reduced;
  logic               div_start;
  logic               div_done;
  logic [W-1:0]       div_q;
  state_t             after_op;
  logic [pfe_pkg::FLAG_W-1:0]  op_flags;
  logic [pfe_pkg::FLAG_W-1:0]  out_flags;

  assign s_tready = (state == S_IDLE) && !rst;

  always_comb begin
    full          = (stack_count == CNT_W'(STACK_DEPTH));
    short_stack   = (stack_count <= CNT_W'(1));
    out_free      = ~m_tvalid | m_tready;
    emit          = (state == S_FINAL) && !in_num && out_free;
    // A pop from an empty stack reads as all ones.
    r_opnd        = (stack_count == '0) ? '1 : cell_val[0];
    l_opnd        = short_stack ? '1 : cell_val[1];
    count_reduced = short_stack ? CNT_W'(1) : stack_count - CNT_W'(1);
    after_op      = last_r ? S_FINAL : S_IDLE;
    case (sym_r)
      pfe_pkg::CH_PLUS:  alu_res = l_opnd + r_opnd;
      pfe_pkg::CH_MINUS: alu_res = l_opnd - r_opnd;
      pfe_pkg::CH_TIMES: alu_res = l_opnd * r_opnd;
      default:           alu_res = '0;
    endcase
    div_start = (state == S_OP) && (sym_r == pfe_pkg::CH_SLASH) && (r_opnd != '0);
    op_flags  = '0;
    op_flags[pfe_pkg::FLAG_UNDER] = short_stack;
    op_flags[pfe_pkg::FLAG_DIVZ]  = (sym_r == pfe_pkg::CH_SLASH) && (r_opnd == '0);
    // The final pop of an empty stack also counts as an underflow.
    out_flags = flags;
    if (stack_count == '0) begin
      out_flags[pfe_pkg::FLAG_UNDER] = 1'b1;
    end
  end

  // Push moves every cell one place down; a reduction writes the top cell
  // and moves the cells below it up by one.
  always_comb begin
    ctrl_top  = pfe_pkg::CELL_HOLD;
    ctrl_rest = pfe_pkg::CELL_HOLD;
    top_in    = acc;
    case (state)
      S_NUM: begin
        if (!full) begin
          ctrl_top  = pfe_pkg::CELL_TAKE_ABOVE;
          ctrl_rest = pfe_pkg::CELL_TAKE_ABOVE;
        end
      end
      S_FINAL: begin
        if (in_num && !full) begin
          ctrl_top  = pfe_pkg::CELL_TAKE_ABOVE;
          ctrl_rest = pfe_pkg::CELL_TAKE_ABOVE;
        end
      end
      S_OP: begin
        if (!div_start) begin
          top_in    = alu_res;
          ctrl_top  = pfe_pkg::CELL_TAKE_ABOVE;
          ctrl_rest = pfe_pkg::CELL_TAKE_BELOW;
        end
      end
      S_DIV: begin
        if (div_done) begin
          top_in    = div_q;
          ctrl_top  = pfe_pkg::CELL_TAKE_ABOVE;
          ctrl_rest = pfe_pkg::CELL_TAKE_BELOW;
        end
      end
      default: begin
        ctrl_top  = pfe_pkg::CELL_HOLD;
        ctrl_rest = pfe_pkg::CELL_HOLD;
      end
    endcase
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [W-1:0]      above;
    logic [W-1:0]      below;
    pfe_pkg::cell_op_t ctrl;
    if (i == 0) begin : g_top
      assign above = top_in;
      assign ctrl  = ctrl_top;
    end else begin : g_inner
      assign above = cell_val[i-1];
      assign ctrl  = ctrl_rest;
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below = cell_val[i];
    end else begin : g_mid
      assign below = cell_val[i+1];
    end
    pfe_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .from_above (above),
      .from_below (below),
      .value      (cell_val[i])
    );
  end

  pfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (l_opnd),
    .divisor  (r_opnd),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      acc         <= '0;
      in_num      <= 1'b0;
      stack_count <= '0;
      flags       <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !emit) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            sym_r  <= s_tdata;
            last_r <= s_tlast;
            if (pfe_pkg::is_digit(s_tdata)) begin
              // The low nibble of an ASCII digit is its value.
              acc    <= (acc << 3) + (acc << 1) + W'(s_tdata[3:0]);
              in_num <= 1'b1;
              if (s_tlast) begin
                state <= S_FINAL;
              end
            end else if (in_num) begin
              state <= S_NUM;
            end else if (pfe_pkg::is_arith_op(s_tdata)) begin
              state <= S_OP;
            end else if (s_tlast) begin
              state <= S_FINAL;
            end
          end
        end
        S_NUM: begin
          if (full) begin
            flags[pfe_pkg::FLAG_OVER] <= 1'b1;
          end else begin
            stack_count <= stack_count + CNT_W'(1);
          end
          acc    <= '0;
          in_num <= 1'b0;
          state  <= pfe_pkg::is_arith_op(sym_r) ? S_OP : after_op;
        end
        S_OP: begin
          flags <= flags | op_flags;
          if (div_start) begin
            state <= S_DIV;
          end else begin
            stack_count <= count_reduced;
            state       <= after_op;
          end
        end
        S_DIV: begin
          if (div_done) begin
            stack_count <= count_reduced;
            state       <= after_op;
          end
        end
        S_FINAL: begin
          if (in_num) begin
            if (full) begin
              flags[pfe_pkg::FLAG_OVER] <= 1'b1;
            end else begin
              stack_count <= stack_count + CNT_W'(1);
            end
            acc    <= '0;
            in_num <= 1'b0;
          end else if (out_free) begin
            m_tvalid    <= 1'b1;
            m_tdata     <= r_opnd;
            m_tuser     <= out_flags;
            stack_count <= '0;
            flags       <= '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside of a division");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FINAL))
    else $error("result word raised outside of expression end");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL && !in_num && out_free) |=>
      (stack_count == '0 && flags == '0 && state == S_IDLE))
    else $error("state not cleared after result");
`endif

endmodule

`default_nettype wire

[sim/testbench.sv]
module testbench;

  localparam int DEPTH = pfe_pkg::DEFAULT_STACK_DEPTH;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SYMBOL_BUDGET = 1350;
  localparam int MAX_REPORTS = 10;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [31:0] value;
    logic        underflow;
    logic        overflow;
    logic        divide_by_zero;
  } eval_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;

  postfix_expression_evaluator #(
    .STACK_DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #4 clk = ~clk;

  // Predicted evaluator state.
  logic [31:0]                operand_mem [DEPTH];
  int unsigned                depth_used = 0;
  logic [31:0]                pending_num = '0;
  logic                       num_open = 1'b0;
  logic [pfe_pkg::FLAG_W-1:0] sticky_flags = '0;

  eval_result_t expected_results[$];
  eval_result_t want;
  logic [7:0]   expr_text[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int symbols_sent = 0;
  int expressions_sent = 0;
  int results_checked = 0;
  int failures = 0;
  int cycles = 0;
  int under_seen = 0;
  int over_seen = 0;
  int divz_seen = 0;

  function automatic void push_operand(logic [31:0] v);
    if (depth_used >= DEPTH) begin
      sticky_flags[pfe_pkg::FLAG_OVER] = 1'b1;
    end else begin
      operand_mem[depth_used] = v;
      depth_used++;
    end
  endfunction

  function automatic logic [31:0] pop_operand();
    if (depth_used == 0) begin
      sticky_flags[pfe_pkg::FLAG_UNDER] = 1'b1;
      return 32'hFFFF_FFFF;
    end
    depth_used--;
    return operand_mem[depth_used];
  endfunction

  // Truncating signed division done on magnitudes, so the minimum over minus one wraps.
  function automatic logic [31:0] divide_trunc(logic [31:0] num, logic [31:0] den);
    logic [31:0] mag_n, mag_d, quo;
    if (den == '0) begin
      sticky_flags[pfe_pkg::FLAG_DIVZ] = 1'b1;
      return '0;
    end
    mag_n = num[31] ? 32'd0 - num : num;
    mag_d = den[31] ? 32'd0 - den : den;
    quo = mag_n / mag_d;
    return (num[31] ^ den[31]) ? 32'd0 - quo : quo;
  endfunction

  function automatic void close_number();
    if (num_open) begin
      push_operand(pending_num);
      pending_num = '0;
      num_open = 1'b0;
    end
  endfunction

  function automatic void evaluate_symbol(logic [7:0] sym, logic last);
    logic [31:0] rhs, lhs;
    eval_result_t res;
    if (sym >= pfe_pkg::CH_ZERO && sym <= pfe_pkg::CH_NINE) begin
      pending_num = pending_num * 32'd10 + 32'(sym - pfe_pkg::CH_ZERO);
      num_open = 1'b1;
    end else begin
      close_number();
      if (sym == pfe_pkg::CH_PLUS || sym == pfe_pkg::CH_TIMES ||
          sym == pfe_pkg::CH_MINUS || sym == pfe_pkg::CH_SLASH) begin
        rhs = pop_operand();
        lhs = pop_operand();
        case (sym)
          pfe_pkg::CH_PLUS:  push_operand(lhs + rhs);
          pfe_pkg::CH_TIMES: push_operand(lhs * rhs);
          pfe_pkg::CH_MINUS: push_operand(lhs - rhs);
          default:           push_operand(divide_trunc(lhs, rhs));
        endcase
      end
    end
    if (last) begin
      close_number();
      res.value = pop_operand();
      res.underflow = sticky_flags[pfe_pkg::FLAG_UNDER];
      res.overflow = sticky_flags[pfe_pkg::FLAG_OVER];
      res.divide_by_zero = sticky_flags[pfe_pkg::FLAG_DIVZ];
      expected_results.push_back(res);
      under_seen += int'(res.underflow);
      over_seen += int'(res.overflow);
      divz_seen += int'(res.divide_by_zero);
      depth_used = 0;
      pending_num = '0;
      num_open = 1'b0;
      sticky_flags = '0;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("Mismatch in %s: expected %h, got %h", name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("Unexpected result word: value %h, flags %b", m_tdata, m_tuser);
      end else begin
        want = expected_results.pop_front();
        check_field("value", want.value, m_tdata);
        check_field("underflow", 32'(want.underflow),
                    32'(m_tuser[pfe_pkg::FLAG_UNDER]));
        check_field("overflow", 32'(want.overflow),
                    32'(m_tuser[pfe_pkg::FLAG_OVER]));
        check_field("divide_by_zero", 32'(want.divide_by_zero),
                    32'(m_tuser[pfe_pkg::FLAG_DIVZ]));
        results_checked++;
      end
    end
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_symbol(input logic [7:0] sym, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= sym;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    evaluate_symbol(sym, last);
    symbols_sent++;
  endtask

  // Sends the buffered expression with tlast on its final word.
  task automatic send_expression();
    for (int i = 0; i < expr_text.size(); i++)
      send_symbol(expr_text[i], i == expr_text.size() - 1);
    expressions_sent++;
    expr_text = {};
  endtask

  function automatic void put_digits(string s);
    for (int i = 0; i < s.len(); i++)
      expr_text.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_filler();
    logic [7:0] sym;
    if ($urandom_range(3) != 0)
      return CH_SPACE;
    do begin
      sym = 8'($urandom_range(255));
    end while ((sym >= pfe_pkg::CH_ZERO && sym <= pfe_pkg::CH_NINE) ||
               sym == pfe_pkg::CH_PLUS || sym == pfe_pkg::CH_TIMES ||
               sym == pfe_pkg::CH_MINUS || sym == pfe_pkg::CH_SLASH);
    return sym;
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(3))
      0:       return pfe_pkg::CH_PLUS;
      1:       return pfe_pkg::CH_TIMES;
      2:       return pfe_pkg::CH_MINUS;
      default: return pfe_pkg::CH_SLASH;
    endcase
  endfunction

  // Lengths are biased toward single zeros and short numbers, with a few long
  // enough to wrap the accumulator.
  function automatic void put_number(int max_len);
    int kind, len;
    kind = $urandom_range(9);
    if (kind < 2)
      len = 0;
    else if (kind < 7 || max_len <= 3)
      len = $urandom_range(1, (max_len < 3) ? max_len : 3);
    else if (kind < 9)
      len = $urandom_range(4, 10);
    else
      len = $urandom_range(11, 14);
    if (len == 0)
      expr_text.push_back(pfe_pkg::CH_ZERO);
    for (int i = 0; i < len; i++)
      expr_text.push_back(pfe_pkg::CH_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic void build_random_expression();
    int mode, operands, stacked, tokens;
    logic prev_num;
    mode = $urandom_range(99);
    prev_num = 1'b0;
    if (mode < 75) begin
      operands = $urandom_range(1, 6);
      stacked = 0;
      while (operands > 0 || stacked > 1) begin
        if (operands > 0 && (stacked < 2 || $urandom_range(1))) begin
          if (prev_num)
            expr_text.push_back(pick_filler());
          put_number(14);
          prev_num = 1'b1;
          stacked++;
          operands--;
        end else begin
          if (prev_num && $urandom_range(1))
            expr_text.push_back(pick_filler());
          expr_text.push_back(pick_operator());
          prev_num = 1'b0;
          stacked--;
        end
      end
      if ($urandom_range(3) == 0)
        expr_text.push_back(pick_filler());
    end else if (mode < 90) begin
      // Operators and numbers in any order, which mostly runs the stack dry.
      tokens = $urandom_range(1, 8);
      for (int i = 0; i < tokens; i++) begin
        if ($urandom_range(1)) begin
          if (prev_num)
            expr_text.push_back(pick_filler());
          put_number(14);
          prev_num = 1'b1;
        end else begin
          expr_text.push_back(pick_operator());
          prev_num = 1'b0;
        end
      end
    end else begin
      tokens = $urandom_range(1, 6);
      for (int i = 0; i < tokens; i++)
        expr_text.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic test_directed_cases();
    // Minimum value divided by minus one wraps back to the minimum.
    put_digits("2147483648");
    expr_text.push_back(CH_SPACE);
    put_digits("0");
    expr_text.push_back(CH_SPACE);
    put_digits("1");
    expr_text.push_back(pfe_pkg::CH_MINUS);
    expr_text.push_back(pfe_pkg::CH_SLASH);
    send_expression();
    // Zero divisor.
    put_digits("7");
    expr_text.push_back(CH_SPACE);
    put_digits("0");
    expr_text.push_back(pfe_pkg::CH_SLASH);
    send_expression();
    // The left operand of the subtraction is popped from an empty stack.
    put_digits("9");
    expr_text.push_back(pfe_pkg::CH_MINUS);
    send_expression();
    // Empty expressions closed by the lowest and highest symbol codes.
    expr_text.push_back(8'h00);
    send_expression();
    expr_text.push_back(8'hFF);
    send_expression();
    put_digits("6");
    expr_text.push_back(CH_SPACE);
    put_digits("3");
    expr_text.push_back(pfe_pkg::CH_TIMES);
    put_digits("1");
    expr_text.push_back(pfe_pkg::CH_PLUS);
    send_expression();
  endtask

  task automatic test_stack_depth();
    // Exactly full: the last number goes in on the operator, nothing is dropped.
    for (int i = 0; i < DEPTH; i++) begin
      if (i != 0)
        expr_text.push_back(CH_SPACE);
      put_number(1);
    end
    expr_text.push_back(pfe_pkg::CH_PLUS);
    send_expression();
    // One more than fits: the final number is dropped at the end.
    for (int i = 0; i <= DEPTH; i++) begin
      if (i != 0)
        expr_text.push_back(CH_SPACE);
      put_number(1);
    end
    send_expression();
  endtask

  task automatic test_random_traffic();
    int idle_set[4] = '{0, 65, 0, 20};
    int stall_set[4] = '{0, 0, 65, 20};
    int stop_at;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      stop_at = symbols_sent + (SYMBOL_BUDGET - symbols_sent) / (4 - p);
      while (symbols_sent < stop_at) begin
        build_random_expression();
        send_expression();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_stack_depth();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Evaluated %0d expressions from %0d symbols; %0d results checked.",
             expressions_sent, symbols_sent, results_checked);
    $display("Results with underflow %0d, overflow %0d, zero divisor %0d.",
             under_seen, over_seen, divz_seen);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
